>>> rtl/core/vm3_pkg.sv
package vm3_pkg;

	localparam int AXIS_W     = 15;
	localparam int SQ_W       = 29;
	localparam int SUM_W      = 30;
	localparam int MAG_W      = 15;
	localparam int ROOT_STEPS = 15;
	localparam int SQ_STAGES  = 2;
	localparam int LATENCY    = SQ_STAGES + 1 + ROOT_STEPS;

	localparam logic [SUM_W-1:0] ROOT_START = SUM_W'(32'h1000_0000);
	localparam logic [MAG_W-1:0] MAG_MAX    = MAG_W'(28377);

	typedef logic signed [AXIS_W-1:0] axis_t;
	typedef logic [AXIS_W-1:0]        axis_abs_t;
	typedef logic [SQ_W-1:0]          square_t;
	typedef logic [SUM_W-1:0]         sum_t;
	typedef logic [MAG_W-1:0]         mag_t;

endpackage

>>> rtl/core/vm3_square.sv
module vm3_square (
	input  logic          clk,
	input  vm3_pkg::axis_t axis,
	output vm3_pkg::square_t square_s2
);
	import vm3_pkg::*;

	axis_abs_t axis_u;
	axis_abs_t abs_w;
	axis_abs_t abs_s1;

	// most negative input maps to 2^14, which still fits unsigned
	assign axis_u = axis_abs_t'(axis);
	assign abs_w  = axis[AXIS_W-1] ? (~axis_u + axis_abs_t'(1)) : axis_u;

	always_ff @(posedge clk) begin
		abs_s1    <= abs_w;
		square_s2 <= SQ_W'(abs_s1) * SQ_W'(abs_s1);
	end

endmodule

>>> rtl/core/vm3_root_cell.sv
module vm3_root_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_in,
	input  vm3_pkg::sum_t rem_in,
	input  vm3_pkg::sum_t root_in,
	input  vm3_pkg::sum_t step_bit,
	output logic          valid_q,
	output vm3_pkg::sum_t rem_q,
	output vm3_pkg::sum_t root_q
);
	import vm3_pkg::*;

	logic [SUM_W:0] trial;
	logic           fits;
	sum_t           root_sh;
	sum_t           rem_nx;
	sum_t           root_nx;

	assign trial   = {1'b0, root_in} + {1'b0, step_bit};
	assign fits    = trial <= {1'b0, rem_in};
	assign root_sh = root_in >> 1;
	assign rem_nx  = fits ? (rem_in - trial[SUM_W-1:0]) : rem_in;
	assign root_nx = fits ? (root_sh + step_bit) : root_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= rem_nx;
		root_q <= root_nx;
	end

endmodule

>>> rtl/core/vector_magnitude_3d.sv
// Channel  | Ports                         | Beat marked by
// ---------+-------------------------------+---------------------
// sample   | x_axis, y_axis, z_axis        | start high, busy low
// result   | magnitude                     | done high, one cycle
//
// One sample per cycle; busy never rises.
// Stages: abs and square (2), sum (1), one root cell per
// two-bit digit (15).
// arst_n clears only the valid chain; no state survives between samples.
// The receiver cannot stall: each result is on magnitude for the one
// cycle that done is high.
module vector_magnitude_3d (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  vm3_pkg::axis_t  x_axis,
	input  vm3_pkg::axis_t  y_axis,
	input  vm3_pkg::axis_t  z_axis,
	output logic            done,
	output vm3_pkg::mag_t   magnitude
);
	import vm3_pkg::*;

	logic    accept;
	logic    valid_s1;
	logic    valid_s2;
	logic    valid_s3;
	square_t sq_x_s2;
	square_t sq_y_s2;
	square_t sq_z_s2;
	sum_t    sum_s3;

	logic valid_c [ROOT_STEPS+1];
	sum_t rem_c   [ROOT_STEPS+1];
	sum_t root_c  [ROOT_STEPS+1];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	vm3_square u_sq_x (.clk(clk), .axis(x_axis), .square_s2(sq_x_s2));
	vm3_square u_sq_y (.clk(clk), .axis(y_axis), .square_s2(sq_y_s2));
	vm3_square u_sq_z (.clk(clk), .axis(z_axis), .square_s2(sq_z_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s3 <= SUM_W'(sq_x_s2) + SUM_W'(sq_y_s2) + SUM_W'(sq_z_s2);
	end

	assign valid_c[0] = valid_s3;
	assign rem_c[0]   = sum_s3;
	assign root_c[0]  = '0;

	for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_cell
		localparam sum_t StepBit = ROOT_START >> (2 * g);
		vm3_root_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_in(valid_c[g]),
			.rem_in  (rem_c[g]),
			.root_in (root_c[g]),
			.step_bit(StepBit),
			.valid_q (valid_c[g+1]),
			.rem_q   (rem_c[g+1]),
			.root_q  (root_c[g+1])
		);
	end

	assign done      = valid_c[ROOT_STEPS];
	assign magnitude = root_c[ROOT_STEPS][MAG_W-1:0];

	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("sample beat produced no result");

	a_no_stray: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without a sample beat");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> magnitude <= MAG_MAX)
		else $error("magnitude out of range");

	a_root_fit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> root_c[ROOT_STEPS][SUM_W-1:MAG_W] == '0)
		else $error("root wider than magnitude");

endmodule

>>> tb/tb_vector_magnitude_3d.sv
`timescale 1ns / 1ps

module tb_vector_magnitude_3d;

	import vm3_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 6;
	localparam int PHASE_BEATS  = 337;
	localparam int CYCLE_LIMIT  = 100000;

	typedef struct packed {
		axis_t x;
		axis_t y;
		axis_t z;
	} sample_t;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  start     = 1'b0;
	axis_t x_axis    = '0;
	axis_t y_axis    = '0;
	axis_t z_axis    = '0;
	logic  busy;
	logic  done;
	mag_t  magnitude;

	sample_t sample_q[$];
	mag_t    mag_q[$];
	int      idle_pct  = 0;
	int      n_sent    = 0;
	int      n_checked = 0;
	int      n_errors  = 0;
	int      cycles    = 0;

	vector_magnitude_3d i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.x_axis    (x_axis),
		.y_axis    (y_axis),
		.z_axis    (z_axis),
		.done      (done),
		.magnitude (magnitude)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic logic [31:0] abs_axis(axis_t a);
		logic [31:0] v;
		v = {{17{a[AXIS_W-1]}}, a};
		if (a[AXIS_W-1]) begin
			v = -v;
		end
		return v;
	endfunction

	// floor(sqrt(x^2 + y^2 + z^2)), two radicand bits per step
	function automatic mag_t expected_magnitude(axis_t x, axis_t y, axis_t z);
		logic [31:0] ax, ay, az, rad, res, b, trial;
		ax  = abs_axis(x);
		ay  = abs_axis(y);
		az  = abs_axis(z);
		rad = ax * ax + ay * ay + az * az;
		res = '0;
		b   = 32'(ROOT_START);
		while (b != 0) begin
			trial = res + b;
			res   = res >> 1;
			if (trial <= rad) begin
				rad = rad - trial;
				res = res + b;
			end
			b = b >> 2;
		end
		return mag_t'(res);
	endfunction

	function automatic axis_t random_axis();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			return axis_t'($urandom);
		end else if (pick < 85) begin
			return axis_t'(int'($urandom_range(127)) - 64);
		end else begin
			case ($urandom_range(5))
				0: return axis_t'(-16384);
				1: return axis_t'(-16383);
				2: return axis_t'(16383);
				3: return axis_t'(1);
				4: return axis_t'(-1);
				default: return '0;
			endcase
		end
	endfunction

	task automatic push_sample(int x, int y, int z);
		sample_q.push_back('{x: axis_t'(x), y: axis_t'(y), z: axis_t'(z)});
	endtask

	task automatic wait_drained();
		while (sample_q.size() != 0 || start || mag_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		sample_t s;
		if (!arst_n) begin
			start  <= 1'b0;
			x_axis <= '0;
			y_axis <= '0;
			z_axis <= '0;
		end else begin
			if (start && !busy) begin
				mag_q.push_back(expected_magnitude(x_axis, y_axis, z_axis));
				n_sent++;
			end
			if (!start || !busy) begin
				if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					s = sample_q.pop_front();
					start  <= 1'b1;
					x_axis <= s.x;
					y_axis <= s.y;
					z_axis <= s.z;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		mag_t want;
		if (arst_n && done) begin
			if (mag_q.size() == 0) begin
				$error("magnitude: no beat expected, got %0d", magnitude);
				n_errors++;
			end else begin
				want = mag_q.pop_front();
				if (magnitude !== want) begin
					$error("magnitude: expected %0d, got %0d", want, magnitude);
					n_errors++;
				end
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[vector_magnitude_3d] ERROR");
			$finish;
		end
	end

	initial begin
		int phase_idle[4];
		phase_idle = '{0, 53, 0, 17};

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		push_sample(0, 0, 0);
		push_sample(16383, 16383, 16383);
		push_sample(-16384, -16384, -16384);
		push_sample(-16384, 16383, -16384);
		push_sample(-16384, 0, 0);
		push_sample(0, -16384, 0);
		push_sample(0, 0, 16383);
		push_sample(16383, 0, 0);
		push_sample(1, 0, 0);
		push_sample(0, 0, -1);
		push_sample(-1, -1, -1);
		push_sample(1, 1, 2);
		push_sample(2, 2, 1);
		push_sample(3, 4, 0);
		push_sample(-2, 3, -6);
		push_sample(12, 16, 15);
		push_sample(12, 16, 14);
		push_sample(-8192, 8192, 0);
		push_sample(10922, -10923, 10922);
		push_sample(0, 16383, -16384);
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			for (int half = 0; half < 2; half++) begin
				for (int i = 0; i < PHASE_BEATS / 2 + half; i++) begin
					sample_q.push_back('{x: random_axis(), y: random_axis(),
						z: random_axis()});
				end
				// hold off until every result is back
				wait_drained();
			end
		end

		repeat (LATENCY + 4) @(posedge clk);
		@(negedge clk);

		$display("Sent %0d samples (directed extremes, then four pacing phases);",
			n_sent);
		$display("checked %0d magnitudes, %0d mismatches.", n_checked, n_errors);
		if (n_errors == 0) begin
			$display("[vector_magnitude_3d] OK");
		end else begin
			$display("[vector_magnitude_3d] ERROR");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/vm3_pkg.sv
rtl/core/vm3_square.sv
rtl/core/vm3_root_cell.sv
rtl/core/vector_magnitude_3d.sv
tb/tb_vector_magnitude_3d.sv
